// ===== rtl/acpe_pkg.sv =====
package acpe_pkg;

    localparam int unsigned POS_W  = 24;
    localparam int unsigned REG_W  = 28;
    localparam int unsigned OUT_W  = 48;
    localparam int unsigned ADDR_W = 4;
    localparam int unsigned DATA_W = 32;

    localparam logic [REG_W-1:0] AMP_A_RST      = 28'd167772;
    localparam logic [REG_W-1:0] RATE_B_RST     = 28'd26843546;
    localparam logic [REG_W-1:0] COUPLING_C_RST = 28'd83886;
    localparam logic [REG_W-1:0] WIDTH_D_RST    = 28'd16777216;

    localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
    localparam logic [13:0] CURV_Q16  = 14'd15743;

    typedef enum logic [1:0] {
        REG_AMP_A      = 2'd0,
        REG_RATE_B     = 2'd1,
        REG_COUPLING_C = 2'd2,
        REG_WIDTH_D    = 2'd3
    } t_reg_idx;

    // 2^(-j/16), Q31
    function automatic logic [31:0] pow2_tab(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'd2147483648;
            5'd1:    v = 32'd2056437387;
            5'd2:    v = 32'd1969251188;
            5'd3:    v = 32'd1885761398;
            5'd4:    v = 32'd1805811301;
            5'd5:    v = 32'd1729250827;
            5'd6:    v = 32'd1655936265;
            5'd7:    v = 32'd1585730000;
            5'd8:    v = 32'd1518500250;
            5'd9:    v = 32'd1454120817;
            5'd10:   v = 32'd1392470869;
            5'd11:   v = 32'd1333434672;
            5'd12:   v = 32'd1276901417;
            5'd13:   v = 32'd1222764986;
            5'd14:   v = 32'd1170923762;
            5'd15:   v = 32'd1121280436;
            5'd16:   v = 32'd1073741824;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/avoided_crossing_potential_eval_core.sv =====
// Two-state simple avoided crossing evaluator. Each item is one position x (Q16); each result
// carries H00, H01, dH00/dx and dH01/dx (Q32, dH01/dx saturated). The pipeline is 13 register
// stages deep: one item enters per cycle while the output side keeps taking, and a stalled
// output holds the whole pipeline. The two exponentials run in parallel lanes of a five-stage
// table-plus-interpolation unit. Coefficients must be written over the APB port only while
// the block is idle; the block itself does not enforce this.
module avoided_crossing_potential_eval_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [acpe_pkg::POS_W-1:0]   i_s_tdata,   // position
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [4*acpe_pkg::OUT_W-1:0] o_m_tdata,   // h_diag, h_coupling, dh_diag, dh_coupling
    input  logic                         i_psel,
    input  logic                         i_penable,
    input  logic                         i_pwrite,
    input  logic [acpe_pkg::ADDR_W-1:0]  i_paddr,
    input  logic [acpe_pkg::DATA_W-1:0]  i_pwdata,
    output logic [acpe_pkg::DATA_W-1:0]  o_prdata,
    output logic                         o_pready
);

    localparam int NS = 13;

    logic [acpe_pkg::REG_W-1:0] r_a, r_b, r_c, r_d;
    logic [32:0] r_ab, r_cd;
    logic [55:0] ab_full, cd_full;
    logic        en;
    logic        wr;
    acpe_pkg::t_reg_idx widx;

    logic [NS:1]   r_vld;
    logic [23:0]   r_ax  [1:11];
    logic          r_pos [1:12];

    logic [23:0]   in_ax;
    logic          in_neg;

    logic [51:0]   r_tb2;
    logic [47:0]   r_sq;
    logic [51:0]   r_tb3;
    logic [30:0]   r_x2;
    logic [59:0]   r_t      [2];
    logic [59:0]   r_e1_pr  [2];
    logic          r_e1_z   [2];
    logic [31:0]   r_e2_tj  [2];
    logic [46:0]   r_e2_lp  [2];
    logic [18:0]   r_e2_p   [2];
    logic [4:0]    r_e2_n   [2];
    logic          r_e2_z   [2];
    logic [31:0]   r_e3_lin [2];
    logic [32:0]   r_e3_tp  [2];
    logic [4:0]    r_e3_n   [2];
    logic          r_e3_z   [2];
    logic [31:0]   r_e4_lin [2];
    logic [46:0]   r_e4_cp  [2];
    logic [4:0]    r_e4_n   [2];
    logic          r_e4_z   [2];
    logic [31:0]   r_e      [2];

    logic [59:0]   r_md, r_pc;
    logic [64:0]   r_pab, r_pcd;
    logic [37:0]   r_hd, r_hc, r_hd3, r_hc3;
    logic [41:0]   r_dhd, r_dhd3;
    logic [36:0]   r_cde;
    logic [43:0]   r_lo;
    logic [42:0]   r_hi;
    logic [acpe_pkg::OUT_W-1:0] r_o_hd, r_o_hc, r_o_dhd, r_o_dhc;

    logic [29:0]   u     [2];
    logic [31:0]   tj    [2];
    logic [31:0]   tj1   [2];
    logic [20:0]   dcomp [2];
    logic [31:0]   mdiff [2];
    logic [31:0]   n_e   [2];
    logic [50:0]   tp_full [2];

    logic [62:0]   dhc_sum;
    logic [50:0]   dhc_mag;
    logic [acpe_pkg::OUT_W-1:0] n_dhc;

    // configuration
    assign o_pready = 1'b1;
    assign wr       = i_psel && i_penable && i_pwrite;
    assign widx     = acpe_pkg::t_reg_idx'(i_paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a <= acpe_pkg::AMP_A_RST;
            r_b <= acpe_pkg::RATE_B_RST;
            r_c <= acpe_pkg::COUPLING_C_RST;
            r_d <= acpe_pkg::WIDTH_D_RST;
        end else if (wr) begin
            case (widx)
                acpe_pkg::REG_AMP_A:      r_a <= i_pwdata[acpe_pkg::REG_W-1:0];
                acpe_pkg::REG_RATE_B:     r_b <= i_pwdata[acpe_pkg::REG_W-1:0];
                acpe_pkg::REG_COUPLING_C: r_c <= i_pwdata[acpe_pkg::REG_W-1:0];
                acpe_pkg::REG_WIDTH_D:    r_d <= i_pwdata[acpe_pkg::REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (widx)
            acpe_pkg::REG_AMP_A:      o_prdata = {4'd0, r_a};
            acpe_pkg::REG_RATE_B:     o_prdata = {4'd0, r_b};
            acpe_pkg::REG_COUPLING_C: o_prdata = {4'd0, r_c};
            acpe_pkg::REG_WIDTH_D:    o_prdata = {4'd0, r_d};
            default:                  o_prdata = '0;
        endcase
    end

    // rounded products of coefficient pairs
    assign ab_full = r_a * r_b;
    assign cd_full = r_c * r_d;

    always_ff @(posedge i_clk) begin
        r_ab <= 33'((57'(ab_full) + 57'(1 << 23)) >> 24);
        r_cd <= 33'((57'(cd_full) + 57'(1 << 23)) >> 24);
    end

    // pipeline control
    assign en         = !r_vld[NS] || i_m_tready;
    assign o_s_tready = en;
    assign o_m_tvalid = r_vld[NS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NS-1:1], i_s_tvalid};
        end
    end

    assign in_neg = i_s_tdata[23];
    assign in_ax  = in_neg ? (24'd0 - i_s_tdata) : i_s_tdata;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ax[1]  <= in_ax;
            r_pos[1] <= !in_neg && (i_s_tdata != '0);
            for (int k = 2; k <= 11; k++) begin
                r_ax[k] <= r_ax[k-1];
            end
            for (int k = 2; k <= 12; k++) begin
                r_pos[k] <= r_pos[k-1];
            end
        end
    end

    // arguments
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tb2 <= r_b * r_ax[1];
            r_sq  <= r_ax[1] * r_ax[1];
            r_tb3 <= r_tb2;
            r_x2  <= 31'((49'(r_sq) + 49'(1 << 15)) >> 16);
            r_t[0] <= 60'(r_tb3);
            r_t[1] <= 60'(r_d * r_x2);
        end
    end

    // exp(-t) lanes: 0 diagonal, 1 coupling
    always_comb begin
        for (int k = 0; k < 2; k++) begin
            u[k]     = r_e1_pr[k][59:30];
            tj[k]    = acpe_pkg::pow2_tab({1'b0, u[k][23:20]});
            tj1[k]   = acpe_pkg::pow2_tab(5'({1'b0, u[k][23:20]} + 5'd1));
            dcomp[k] = 21'(1 << 20) - {1'b0, u[k][19:0]};
            tp_full[k] = r_e2_tj[k] * r_e2_p[k];
            mdiff[k] = r_e4_lin[k] - 32'(r_e4_cp[k][46:26]);
            n_e[k]   = r_e4_z[k] ? 32'd0 : (mdiff[k] >> r_e4_n[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 2; k++) begin
                r_e1_pr[k]  <= r_t[k][44:16] * acpe_pkg::LOG2E_Q30;
                r_e1_z[k]   <= (r_t[k][59:45] != '0);
                r_e2_tj[k]  <= tj[k];
                r_e2_lp[k]  <= 27'(tj[k] - tj1[k]) * u[k][19:0];
                r_e2_p[k]   <= 19'((41'(u[k][19:0]) * 41'(dcomp[k])) >> 20);
                r_e2_n[k]   <= u[k][28:24];
                r_e2_z[k]   <= r_e1_z[k] || u[k][29];
                r_e3_lin[k] <= r_e2_tj[k] - 32'(r_e2_lp[k][46:20]);
                r_e3_tp[k]  <= tp_full[k][50:18];
                r_e3_n[k]   <= r_e2_n[k];
                r_e3_z[k]   <= r_e2_z[k];
                r_e4_lin[k] <= r_e3_lin[k];
                r_e4_cp[k]  <= r_e3_tp[k] * acpe_pkg::CURV_Q16;
                r_e4_n[k]   <= r_e3_n[k];
                r_e4_z[k]   <= r_e3_z[k];
                r_e[k]      <= n_e[k];
            end
        end
    end

    // output terms
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_md  <= r_a * (32'h8000_0000 - r_e[0]);
            r_pab <= r_ab * r_e[0];
            r_pc  <= r_c * r_e[1];
            r_pcd <= r_cd * r_e[1];

            r_hd  <= 38'((61'(r_md) + 61'(1 << 22)) >> 23);
            r_dhd <= 42'((66'(r_pab) + 66'(1 << 22)) >> 23);
            r_hc  <= 38'((61'(r_pc) + 61'(1 << 22)) >> 23);
            r_cde <= 37'((66'(r_pcd) + 66'(1 << 26)) >> 27);

            r_lo   <= {r_ax[11], 1'b0} * r_cde[18:0];
            r_hi   <= {r_ax[11], 1'b0} * r_cde[36:19];
            r_hd3  <= r_hd;
            r_dhd3 <= r_dhd;
            r_hc3  <= r_hc;

            r_o_hd  <= r_pos[12] ? 48'(r_hd3) : (48'd0 - 48'(r_hd3));
            r_o_hc  <= 48'(r_hc3);
            r_o_dhd <= 48'(r_dhd3);
            r_o_dhc <= n_dhc;
        end
    end

    assign dhc_sum = {r_hi, 19'd0} + 63'(r_lo) + 63'(1 << 11);
    assign dhc_mag = dhc_sum[62:12];

    always_comb begin
        if (r_pos[12]) begin
            n_dhc = (dhc_mag > 51'h0_8000_0000_0000) ? 48'h8000_0000_0000
                                                      : (48'd0 - dhc_mag[47:0]);
        end else begin
            n_dhc = (dhc_mag > 51'h0_7FFF_FFFF_FFFF) ? 48'h7FFF_FFFF_FFFF
                                                      : dhc_mag[47:0];
        end
    end

    assign o_m_tdata = {r_o_dhc, r_o_dhd, r_o_hc, r_o_hd};

    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_vld[NS-1]) |=> o_m_tvalid)
        else $error("pipeline dropped an item");

    a_hc_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !o_m_tdata[95])
        else $error("negative coupling");

    a_dhd_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !o_m_tdata[143])
        else $error("negative diagonal gradient");

    a_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[47]) |-> !o_m_tdata[191])
        else $error("sign mismatch between diagonal and coupling gradient");

endmodule
